// File: src/real_to_iq_fs4_cic_decimator_macros.svh
// Assertion macros for the fs/4 downconverter and CIC decimator.
// Used by the port checker; expects i_clk and i_rst_n in scope.
`ifndef REAL_TO_IQ_FS4_CIC_DECIMATOR_MACROS_SVH
`define REAL_TO_IQ_FS4_CIC_DECIMATOR_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define R2IQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that also holds across reset
`define R2IQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/r2iq_pkg.sv
// Shared constants, types and helper functions for the fs/4 downconverter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package r2iq_pkg;

    localparam int MAX_ORDER = 5;
    localparam int SAMP_W    = 16;
    localparam int ACC_W     = 24;
    localparam int ORD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int IN_W      = 2 * SAMP_W;
    localparam int OUT_W     = 2 * ACC_W;
    localparam int MSB_SHIFT = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DC_OFFSET    = 2'd0,
        CFG_FILTER_ORDER = 2'd1,
        CFG_MSB_MODE     = 2'd2
    } t_cfg_reg;

    // Per-cycle control shared by both lanes
    typedef struct packed {
        logic                 en;
        logic                 vld;
        logic [MAX_ORDER-1:0] mask;
    } t_lane_ctl;

    // Clamp a 17-bit difference to the 16-bit signed range
    function automatic logic [SAMP_W-1:0] sat16(input logic [SAMP_W:0] d);
        logic [SAMP_W-1:0] r;
        if (d[SAMP_W] != d[SAMP_W-1]) begin
            r = d[SAMP_W] ? {1'b1, {(SAMP_W-1){1'b0}}} : {1'b0, {(SAMP_W-1){1'b1}}};
        end else begin
            r = d[SAMP_W-1:0];
        end
        return r;
    endfunction

    // Stage enable mask; order 0 acts as 1, above MAX_ORDER as MAX_ORDER
    function automatic logic [MAX_ORDER-1:0] order_mask(input logic [ORD_W-1:0] ord);
        logic [ORD_W-1:0]     n;
        logic [MAX_ORDER-1:0] m;
        n = ord;
        if (n == '0) begin
            n = ORD_W'(1);
        end else if (n > ORD_W'(MAX_ORDER)) begin
            n = ORD_W'(MAX_ORDER);
        end
        for (int k = 0; k < MAX_ORDER; k++) begin
            m[k] = (ORD_W'(k) < n);
        end
        return m;
    endfunction

    // Output formatting: full value or arithmetic shift by 8
    function automatic logic [ACC_W-1:0] finish(input logic [ACC_W-1:0] v,
                                                input logic msb);
        logic [ACC_W-1:0] r;
        if (msb) begin
            r = {{MSB_SHIFT{v[ACC_W-1]}}, v[ACC_W-1:MSB_SHIFT]};
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: src/r2iq_mixer.sv
// Offset removal with saturation and fs/4 sign alternation.
// Depends on r2iq_pkg; feeds the I and Q CIC lanes.
`timescale 1ns / 1ps

module r2iq_mixer import r2iq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_accept,
    input  logic [SAMP_W-1:0] i_dc_offset,
    input  logic [SAMP_W-1:0] i_x0,
    input  logic [SAMP_W-1:0] i_x1,
    output logic              o_vld,
    output logic [SAMP_W-1:0] o_a,
    output logic [SAMP_W-1:0] o_b
);

    logic              r_vld, n_vld;
    logic              r_phase, n_phase;
    logic [SAMP_W-1:0] r_a, n_a;
    logic [SAMP_W-1:0] r_b, n_b;
    logic [SAMP_W:0]   w_dc, w_x0, w_x1;

    // Even pairs take x - offset, odd pairs offset - x, both saturated
    always_comb begin
        w_dc    = {i_dc_offset[SAMP_W-1], i_dc_offset};
        w_x0    = {i_x0[SAMP_W-1], i_x0};
        w_x1    = {i_x1[SAMP_W-1], i_x1};
        n_vld   = i_accept;
        n_phase = r_phase ^ i_accept;
        if (r_phase) begin
            n_a = sat16(w_dc - w_x0);
            n_b = sat16(w_dc - w_x1);
        end else begin
            n_a = sat16(w_x0 - w_dc);
            n_b = sat16(w_x1 - w_dc);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= 1'b0;
            r_phase <= 1'b0;
        end else if (i_en) begin
            r_vld   <= n_vld;
            r_phase <= n_phase;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_vld = r_vld;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule

// File: src/r2iq_cic_lane.sv
// One CIC decimate-by-2 lane: pipelined integrators (two sub-samples per
// request) followed by pipelined combs. Depends on r2iq_pkg.
`timescale 1ns / 1ps

module r2iq_cic_lane import r2iq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic [SAMP_W-1:0] i_u1,
    input  logic [SAMP_W-1:0] i_u2,
    output logic              o_vld,
    output logic [ACC_W-1:0]  o_data
);

    localparam int NSTG = 2 * MAX_ORDER;

    logic [NSTG-1:0]  r_vld, n_vld;
    logic [ACC_W-1:0] r_int [MAX_ORDER];
    logic [ACC_W-1:0] n_int [MAX_ORDER];
    logic [ACC_W-1:0] r_p1  [MAX_ORDER];
    logic [ACC_W-1:0] n_p1  [MAX_ORDER];
    logic [ACC_W-1:0] r_p2  [MAX_ORDER];
    logic [ACC_W-1:0] n_p2  [MAX_ORDER];
    logic [ACC_W-1:0] r_d   [MAX_ORDER];
    logic [ACC_W-1:0] n_d   [MAX_ORDER];
    logic [ACC_W-1:0] r_c   [MAX_ORDER];
    logic [ACC_W-1:0] n_c   [MAX_ORDER];
    logic [ACC_W-1:0] w_in1 [MAX_ORDER];
    logic [ACC_W-1:0] w_in2 [MAX_ORDER];
    logic [ACC_W-1:0] w_s1  [MAX_ORDER];
    logic [ACC_W-1:0] w_s2  [MAX_ORDER];
    logic [ACC_W-1:0] w_cin [MAX_ORDER];

    always_comb begin
        // valid of the request entering each stage
        n_vld = {r_vld[NSTG-2:0], i_ctl.vld};

        // stage inputs
        w_in1[0] = {{(ACC_W-SAMP_W){i_u1[SAMP_W-1]}}, i_u1};
        w_in2[0] = {{(ACC_W-SAMP_W){i_u2[SAMP_W-1]}}, i_u2};
        w_cin[0] = r_p2[MAX_ORDER-1];
        for (int k = 1; k < MAX_ORDER; k++) begin
            w_in1[k] = r_p1[k-1];
            w_in2[k] = r_p2[k-1];
            w_cin[k] = r_c[k-1];
        end

        // integrators: two sub-sample updates per stage, wrap at 24 bits
        for (int k = 0; k < MAX_ORDER; k++) begin
            w_s1[k] = r_int[k] + w_in1[k];
            w_s2[k] = w_s1[k] + w_in2[k];
            if (i_ctl.mask[k]) begin
                n_p1[k]  = w_s1[k];
                n_p2[k]  = w_s2[k];
                n_int[k] = n_vld[k] ? w_s2[k] : r_int[k];
            end else begin
                n_p1[k]  = w_in1[k];
                n_p2[k]  = w_in2[k];
                n_int[k] = r_int[k];
            end
        end

        // combs at the pair rate, differential delay 1
        for (int k = 0; k < MAX_ORDER; k++) begin
            if (i_ctl.mask[k]) begin
                n_c[k] = w_cin[k] - r_d[k];
                n_d[k] = n_vld[MAX_ORDER+k] ? w_cin[k] : r_d[k];
            end else begin
                n_c[k] = w_cin[k];
                n_d[k] = r_d[k];
            end
        end
    end

    // Filter state and valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_int[k] <= '0;
                r_d[k]   <= '0;
            end
        end else if (i_ctl.en) begin
            r_vld <= n_vld;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_int[k] <= n_int[k];
                r_d[k]   <= n_d[k];
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_p1[k] <= n_p1[k];
                r_p2[k] <= n_p2[k];
                r_c[k]  <= n_c[k];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_data = r_c[MAX_ORDER-1];

endmodule

// File: src/real_to_iq_fs4_cic_decimator.sv
// Throughput: one sample pair per cycle while the output buffer has room;
// one mixer stage, 5 integrator and 5 comb stages per lane, and a 2-entry
// output buffer that absorbs stalls.
// Reset (synchronous, active low) clears filter state, mix phase and the
// buffer; registers return to offset 0, order 5, full-width results.
// Depends on r2iq_pkg, r2iq_mixer and r2iq_cic_lane.
`timescale 1ns / 1ps

module real_to_iq_fs4_cic_decimator import r2iq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_W-1:0]      i_s_axis_tdata,  // [15:0] sample_first, [31:16] sample_second
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [OUT_W-1:0]     o_m_axis_tdata,  // [23:0] i_result, [47:24] q_result
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [SAMP_W-1:0]    r_dc;
    logic [MAX_ORDER-1:0] r_mask;
    logic                 r_msb;

    // Output buffer
    logic [OUT_W-1:0] r_buf [2];
    logic [1:0]       r_cnt, n_cnt;
    logic             r_wr, r_rd;

    logic              w_en, w_accept, w_push, w_pop;
    logic              w_mix_vld;
    logic [SAMP_W-1:0] w_a, w_b;
    t_lane_ctl         w_ctl;
    logic              w_i_vld, w_q_vld;
    logic [ACC_W-1:0]  w_i_data, w_q_data;
    logic [OUT_W-1:0]  w_item;

    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc   <= '0;
            r_mask <= order_mask(ORD_W'(MAX_ORDER));
            r_msb  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DC_OFFSET:    r_dc   <= i_cfg_data[SAMP_W-1:0];
                CFG_FILTER_ORDER: r_mask <= order_mask(i_cfg_data[ORD_W-1:0]);
                CFG_MSB_MODE:     r_msb  <= i_cfg_data[0];
                default:          r_dc   <= r_dc;
            endcase
        end
    end

    // Pipeline advances while the buffer has room
    assign w_en            = (r_cnt != 2'd2);
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid & w_en;

    r2iq_mixer u_mixer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_accept    (w_accept),
        .i_dc_offset (r_dc),
        .i_x0        (i_s_axis_tdata[SAMP_W-1:0]),
        .i_x1        (i_s_axis_tdata[IN_W-1:SAMP_W]),
        .o_vld       (w_mix_vld),
        .o_a         (w_a),
        .o_b         (w_b)
    );

    assign w_ctl = '{en: w_en, vld: w_mix_vld, mask: r_mask};

    // I lane sees (0, b); Q lane sees (a, 0)
    r2iq_cic_lane u_lane_i (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_u1    ('0),
        .i_u2    (w_b),
        .o_vld   (w_i_vld),
        .o_data  (w_i_data)
    );

    r2iq_cic_lane u_lane_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_u1    (w_a),
        .i_u2    ('0),
        .o_vld   (w_q_vld),
        .o_data  (w_q_data)
    );

    // Merge both lanes into one result and queue it
    assign w_item = {finish(w_q_data, r_msb), finish(w_i_data, r_msb)};
    assign w_push = w_en & w_i_vld & w_q_vld;
    assign w_pop  = o_m_axis_tvalid & i_m_axis_tready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_wr  <= r_wr ^ w_push;
            r_rd  <= r_rd ^ w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= w_item;
        end
    end

    assign o_m_axis_tvalid = (r_cnt != 2'd0);
    assign o_m_axis_tdata  = r_buf[r_rd];

endmodule

// File: src/r2iq_checker.sv
// Port-level checker for the fs/4 downconverter, bound to the top level.
// Depends on real_to_iq_fs4_cic_decimator_macros.svh and r2iq_pkg.
`timescale 1ns / 1ps
`include "real_to_iq_fs4_cic_decimator_macros.svh"

module r2iq_checker import r2iq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    // stalled result holds
    `R2IQ_ASSERT(a_out_hold, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)), "result changed while stalled")

    // input backpressure only comes from a full output buffer
    `R2IQ_ASSERT(a_bp_full, !o_s_axis_tready |-> o_m_axis_tvalid, "input stalled with no result pending")

    // full buffer stays full while the sink stalls
    `R2IQ_ASSERT(a_full_stays, (!o_s_axis_tready && !i_m_axis_tready) |=> !o_s_axis_tready, "input reopened without a result taken")

    // reset empties the buffer and opens the input
    `R2IQ_ASSERT_RST(a_rst_clear, !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready), "reset did not clear the output")

endmodule

bind real_to_iq_fs4_cic_decimator r2iq_checker u_r2iq_checker (.*);

// File: test/testbench.sv
// Self-checking testbench for the fs/4 real-to-IQ downconverter with CIC decimation.
// Needs r2iq_pkg and real_to_iq_fs4_cic_decimator; carries its own mixer and filter model.
`timescale 1ns / 1ps

module testbench;
    import r2iq_pkg::*;

    localparam int NUM_DIRECTED = 21;
    localparam int RANDOM_ITEMS = 630;
    localparam int LAST_PHASE   = 80;   // final stretch runs without idling
    localparam int DRAIN_CYCLES = 20;   // pipeline latency plus margin
    localparam int HOLD_CYCLES  = 80;   // long receiver hold-off

    // One directed row: register settings, sample pair, optional typed result
    typedef struct packed {
        logic [15:0] dc;
        logic [2:0]  order;
        logic        msb;
        logic [15:0] first;
        logic [15:0] second;
        logic        typed;
        logic [23:0] want_i;
        logic [23:0] want_q;
    } t_stim_row;

    typedef struct packed {
        logic [ACC_W-1:0] q;
        logic [ACC_W-1:0] i;
    } t_iq;

    // After reset (order 5, phase 0) the first pair gives I = x1 and Q = 5 * x0
    localparam t_stim_row STIM_TABLE [NUM_DIRECTED] = '{
        '{16'sd0, 3'd5, 1'b0, 16'sd100, -16'sd200, 1'b1, -24'sd200, 24'sd500},
        '{16'sd0, 3'd5, 1'b0, 16'h7fff, 16'h7fff, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd5, 1'b0, 16'h8000, 16'h8000, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd5, 1'b0, 16'h7fff, 16'h8000, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd5, 1'b0, 16'h8000, 16'h7fff, 1'b0, 24'd0, 24'd0},
        // offset at its extremes drives the subtraction into saturation both ways
        '{16'h8000, 3'd5, 1'b0, 16'h7fff, 16'h7fff, 1'b0, 24'd0, 24'd0},
        '{16'h8000, 3'd5, 1'b0, 16'h7fff, 16'hffff, 1'b0, 24'd0, 24'd0},
        '{16'h7fff, 3'd5, 1'b0, 16'h8000, 16'h8000, 1'b0, 24'd0, 24'd0},
        '{16'h7fff, 3'd5, 1'b0, 16'h8000, 16'h7fff, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd1, 1'b0, 16'sd1234, -16'sd4321, 1'b0, 24'd0, 24'd0},
        // order zero behaves as order one
        '{16'sd0, 3'd0, 1'b0, 16'sd500, 16'sd600, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd0, 1'b0, -16'sd500, -16'sd600, 1'b0, 24'd0, 24'd0},
        // orders above the maximum clamp to the maximum
        '{16'sd0, 3'd7, 1'b0, 16'h7fff, 16'h7fff, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd6, 1'b0, 16'h8000, 16'h8000, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd6, 1'b1, 16'h7fff, 16'h7fff, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd5, 1'b1, 16'h8000, 16'h8000, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd5, 1'b1, 16'hffff, 16'sd1, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd2, 1'b1, 16'sd255, -16'sd256, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd3, 1'b0, 16'sd0, 16'sd0, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd4, 1'b0, 16'h5555, 16'haaaa, 1'b0, 24'd0, 24'd0},
        '{16'sd0, 3'd2, 1'b0, 16'haaaa, 16'h5555, 1'b0, 24'd0, 24'd0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata;   // [15:0] sample_first, [31:16] sample_second
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_W-1:0]     o_m_axis_tdata;   // [23:0] i_result, [47:24] q_result
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    real_to_iq_fs4_cic_decimator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Register copies and filter state of the model
    logic signed [15:0] cur_dc;
    logic [ORD_W-1:0]   cur_order;
    logic               cur_msb;
    logic               lo_negate;
    logic [ACC_W-1:0]   integ_acc [2*MAX_ORDER];
    logic [ACC_W-1:0]   comb_dly  [2*MAX_ORDER];

    t_iq pending_iq [$];
    int  error_count;
    bit  sender_gaps;
    bit  rx_gaps;
    bit  hold_request;
    int  hold_count;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [ACC_W-1:0] got,
                                   input logic [ACC_W-1:0] want);
        $display("MISMATCH %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Integrator chain of one lane, one sample
    task automatic integrate_lane(input int lane, input int n, input int x);
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(x);
        for (int k = 0; k < n; k++) begin
            integ_acc[lane*MAX_ORDER+k] = integ_acc[lane*MAX_ORDER+k] + acc;
            acc = integ_acc[lane*MAX_ORDER+k];
        end
    endtask

    // Comb chain of one lane at the pair rate; unused stages keep their values
    task automatic comb_lane(input int lane, input int n, output logic [ACC_W-1:0] v);
        logic [ACC_W-1:0] o;
        v = integ_acc[lane*MAX_ORDER+n-1];
        for (int k = 0; k < n; k++) begin
            o = v - comb_dly[lane*MAX_ORDER+k];
            comb_dly[lane*MAX_ORDER+k] = v;
            v = o;
        end
    endtask

    // 24-bit saturation cannot bite here; only the MSB shift matters
    function automatic logic [ACC_W-1:0] shape_out(input logic [ACC_W-1:0] v);
        if (cur_msb) return ACC_W'($signed(v) >>> MSB_SHIFT);
        return v;
    endfunction

    // Mix one pair down to IQ and run both CIC lanes
    task automatic predict_iq(input logic [15:0] f, input logic [15:0] s, output t_iq r);
        int x0, x1, a, b, n;
        logic [ACC_W-1:0] vi, vq;
        x0 = int'($signed(f));
        x1 = int'($signed(s));
        if (cur_order == '0) n = 1;
        else if (cur_order > ORD_W'(MAX_ORDER)) n = MAX_ORDER;
        else n = int'(cur_order);
        // negated pairs saturate dc - x directly, not the negated difference
        if (lo_negate) begin
            a = clamp16(int'(cur_dc) - x0);
            b = clamp16(int'(cur_dc) - x1);
        end else begin
            a = clamp16(x0 - int'(cur_dc));
            b = clamp16(x1 - int'(cur_dc));
        end
        integrate_lane(0, n, 0);
        integrate_lane(0, n, b);
        integrate_lane(1, n, a);
        integrate_lane(1, n, 0);
        comb_lane(0, n, vi);
        comb_lane(1, n, vq);
        r.i = shape_out(vi);
        r.q = shape_out(vq);
        lo_negate = ~lo_negate;
    endtask

    // Offer one pair, wait for acceptance, queue what it must produce
    task automatic send_pair(input logic [15:0] f, input logic [15:0] s,
                             input logic typed, input t_iq want);
        int  gap;
        t_iq r;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {s, f};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_iq(f, s, r);
        pending_iq.push_back(typed ? want : r);
    endtask

    // Stop offering and let every pending result come out
    task automatic drain_pipeline();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_iq.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DC_OFFSET:    cur_dc    = data;
            CFG_FILTER_ORDER: cur_order = data[ORD_W-1:0];
            CFG_MSB_MODE:     cur_msb   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Unused upper data bits get random values
    task automatic set_config(input logic [15:0] dc, input logic [2:0] order, input logic msb);
        drain_pipeline();
        write_reg(CFG_DC_OFFSET, dc);
        write_reg(CFG_FILTER_ORDER, {13'($urandom), order});
        write_reg(CFG_MSB_MODE, {15'($urandom), msb});
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off when requested
    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_m_axis_tready = 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(negedge i_clk);
                end
                hold_request    = 1'b0;
                i_m_axis_tready = 1'b1;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 13);
                i_m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_iq exp_iq;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_iq.size() == 0) begin
                report_mismatch("result with none pending, i", o_m_axis_tdata[23:0], '0);
            end else begin
                exp_iq = pending_iq.pop_front();
                if (o_m_axis_tdata[23:0] !== exp_iq.i)
                    report_mismatch("i_result", o_m_axis_tdata[23:0], exp_iq.i);
                if (o_m_axis_tdata[47:24] !== exp_iq.q)
                    report_mismatch("q_result", o_m_axis_tdata[47:24], exp_iq.q);
            end
        end
    end

    // Main sequence
    initial begin
        t_stim_row row;
        int sent, len, phase;
        logic [15:0] dc;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_DC_OFFSET;
        i_cfg_data      = '0;
        error_count     = 0;
        sender_gaps     = 1'b1;
        rx_gaps         = 1'b1;
        hold_request    = 1'b0;
        cur_dc          = '0;
        cur_order       = ORD_W'(5);
        cur_msb         = 1'b0;
        lo_negate       = 1'b0;
        for (int k = 0; k < 2*MAX_ORDER; k++) begin
            integ_acc[k] = '0;
            comb_dly[k]  = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table; registers change only between drained phases
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = STIM_TABLE[r];
            if (row.dc != cur_dc || row.order != cur_order || row.msb != cur_msb)
                set_config(row.dc, row.order, row.msb);
            send_pair(row.first, row.second, row.typed, {row.want_q, row.want_i});
        end

        // Random phases, each under fresh register settings
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            if (RANDOM_ITEMS - sent <= LAST_PHASE) begin
                len = RANDOM_ITEMS - sent;
            end else if (phase == 1) begin
                len = 60;
            end else begin
                len = $urandom_range(10, 60);
            end
            case ($urandom_range(0, 5))
                0:       dc = 16'h8000;
                1:       dc = 16'h7fff;
                2:       dc = 16'h0000;
                default: dc = 16'($urandom);
            endcase
            set_config(dc, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            if (RANDOM_ITEMS - sent <= LAST_PHASE) begin
                sender_gaps = 1'b0;
                rx_gaps     = 1'b0;
            end else if (phase == 1 || (len >= 40 && $urandom_range(0, 7) == 0)) begin
                // fill the pipeline and the output buffer until input stalls
                hold_request = 1'b1;
            end
            for (int k = 0; k < len; k++) begin
                send_pair(pick_sample(), pick_sample(), 1'b0, '0);
            end
            sent += len;
            phase++;
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
